// ===== hw/rtl/sdepq_pkg.sv =====
// Package for the sorted double-ended priority queue.
// Holds the request and result types, field widths, codes and the
// controller to datapath command and status structs. No dependencies.
package sdepq_pkg;

  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int OCC_BITS     = 6;
  localparam int DEPTH_DEF    = 32;

  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_POP_MIN = 2'd1,
    MODE_POP_MAX = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                   mode;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic                    out_valid;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    status_t                 status;
    logic [OCC_BITS-1:0]     occupancy;
  } res_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // per-cycle commands from the controller to the datapath
  typedef struct packed {
    logic    capture;      // latch the accepted request
    logic    rd_first;     // read the front entry
    logic    rd_last;      // read the back entry, scan index to back
    logic    rd_prev;      // read entry below scan index, step index down
    logic    wr_shift;     // move read entry one slot up
    logic    wr_new_after; // write new entry above scan index
    logic    wr_new_front; // write new entry at the front
    logic    pop_take;     // take read entry as result, drop it
    logic    res_none;     // result without an entry
    status_t res_status;   // status for res_none
    logic    cnt_inc;      // one more stored entry
    logic    out_load;     // load the output register
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic key_gt;    // read key greater than new key
    logic idx_zero;  // scan index at the front
    logic out_free;  // output register can take a result
  } dp_stat_t;

endpackage

// ===== hw/rtl/sdepq_ctrl.sv =====
// Controller state machine of the sorted double-ended priority queue.
// Sequences push scans, pops and result hand-off; uses sdepq_pkg.
module sdepq_ctrl import sdepq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  mode_t    req_mode,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FRONT = 5'b00100,
    S_POP   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign req_stall = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_status = STATUS_OK;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          unique case (req_mode)
            MODE_PUSH: begin
              if (stat.cnt_full) begin
                cmd.res_none   = 1'b1;
                cmd.res_status = STATUS_FULL;
                state_next     = S_EMIT;
              end else if (stat.cnt_zero) begin
                state_next = S_FRONT;
              end else begin
                cmd.rd_last = 1'b1;
                state_next  = S_SCAN;
              end
            end
            MODE_POP_MIN, MODE_POP_MAX: begin
              if (stat.cnt_zero) begin
                cmd.res_none   = 1'b1;
                cmd.res_status = STATUS_EMPTY;
                state_next     = S_EMIT;
              end else begin
                cmd.rd_first = (req_mode == MODE_POP_MIN);
                cmd.rd_last  = (req_mode == MODE_POP_MAX);
                state_next   = S_POP;
              end
            end
            default: begin
              cmd.res_none = 1'b1;
              state_next   = S_EMIT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (stat.key_gt) begin
          cmd.wr_shift = 1'b1;
          if (stat.idx_zero) begin
            state_next = S_FRONT;
          end else begin
            cmd.rd_prev = 1'b1;
          end
        end else begin
          cmd.wr_new_after = 1'b1;
          cmd.res_none     = 1'b1;
          cmd.cnt_inc      = 1'b1;
          state_next       = S_EMIT;
        end
      end
      S_FRONT: begin
        cmd.wr_new_front = 1'b1;
        cmd.res_none     = 1'b1;
        cmd.cnt_inc      = 1'b1;
        state_next       = S_EMIT;
      end
      S_POP: begin
        cmd.pop_take = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/sdepq_dp.sv =====
// Datapath of the sorted double-ended priority queue: entry memory kept
// as a circular sorted list, head and count, scan index, result and
// output registers. Uses sdepq_pkg.
module sdepq_dp import sdepq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     res_valid,
  input  logic     res_stall,
  output res_t     res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_W  = AW'(DEPTH - 1);

  entry_t        mem [DEPTH];
  entry_t        rdata;
  logic [AW-1:0] head;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] idx;
  entry_t        new_ent;
  mode_t         cap_mode;

  logic                    res_ent_valid;
  logic [KEY_BITS-1:0]     res_key;
  logic [PAYLOAD_BITS-1:0] res_payload;
  status_t                 res_status;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // logical position to physical slot, wrapping at the depth
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                         input logic [AW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, hd} + {1'b0, pos};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign cnt_m1 = cnt - CW'(1);

  // status to the controller
  assign stat.cnt_zero = (cnt == '0);
  assign stat.cnt_full = (cnt == DEPTH_C);
  assign stat.key_gt   = (rdata.key > new_ent.key);
  assign stat.idx_zero = (idx == '0);
  assign stat.out_free = !res_valid || !res_stall;

  // memory address and data selection
  always_comb begin
    rd_en   = cmd.rd_first || cmd.rd_last || cmd.rd_prev;
    rd_addr = head;
    if (cmd.rd_last) begin
      rd_addr = phys(head, cnt_m1[AW-1:0]);
    end else if (cmd.rd_prev) begin
      rd_addr = phys(head, idx - AW'(1));
    end
    wr_en   = cmd.wr_shift || cmd.wr_new_after || cmd.wr_new_front;
    wr_addr = cmd.wr_new_front ? head : phys(head, idx + AW'(1));
    wr_data = cmd.wr_shift ? rdata : new_ent;
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // request capture, scan index and result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_ent.key     <= req.key;
      new_ent.payload <= req.payload;
      cap_mode        <= req.mode;
    end
    if (cmd.rd_last) begin
      idx <= cnt_m1[AW-1:0];
    end else if (cmd.rd_prev) begin
      idx <= idx - AW'(1);
    end
    if (cmd.res_none) begin
      res_ent_valid <= 1'b0;
      res_key       <= '0;
      res_payload   <= '0;
      res_status    <= cmd.res_status;
    end else if (cmd.pop_take) begin
      res_ent_valid <= 1'b1;
      res_key       <= rdata.key;
      res_payload   <= rdata.payload;
      res_status    <= STATUS_OK;
    end
    if (cmd.out_load) begin
      res.out_valid   <= res_ent_valid;
      res.out_key     <= res_key;
      res.out_payload <= res_payload;
      res.status      <= res_status;
      res.occupancy   <= OCC_BITS'(cnt);
    end
  end

  // head, count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.pop_take) begin
        cnt <= cnt_m1;
        if (cap_mode == MODE_POP_MIN) begin
          head <= (head == LAST_W) ? '0 : head + AW'(1);
        end
      end
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/sorted_double_ended_priority_queue.sv =====
// Sorted double-ended priority queue, top level. One request in flight: a push
// scans from the back entry toward the front, one entry per cycle, moving each
// stored key greater than the new key one slot up; a pop takes the front or back
// entry; a refused or no-op request gives a result without an entry. The next
// request is accepted the cycle after the result is loaded.
// Reset empties the queue and drops the output valid; memory contents unknown.
module sorted_double_ended_priority_queue import sdepq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  sdepq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_mode  (req.mode),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and result path
  sdepq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
